/* rtl/core/lfu_lru_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_lru_pkg
// Shared types and constants for the lfu cache with lru tie-break.
// ----------------------------------------------------------------------------
package lfu_lru_pkg;

    // field widths
    localparam int KEY_W   = 32;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 32;
    localparam int CFG_W   = 5;
    localparam int IN_W    = KEY_W + DATA_W;

    // operation codes
    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    // constants
    localparam logic [CFG_W-1:0]   CAP_RESET  = 5'd16;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_INIT = 32'd1;
    localparam logic [DATA_W-1:0]  MISS_VALUE = {DATA_W{1'b1}};
    localparam logic [DATA_W-1:0]  PUT_VALUE  = '0;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;      // capture the input transfer
        logic rd_en;     // read one entry this cycle
        logic rd_scan;   // read belongs to the lookup pass
        logic plan;      // register the decision after the lookup pass
        logic commit;    // update valid bits and occupancy
        logic load_out;  // move the result into the output register
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic out_free;  // output register can take a result this cycle
    } status_t;

endpackage

/* rtl/core/lfu_cache_lru_tiebreak_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_cache_lru_tiebreak_core
// Key-value cache, least-frequently-used replacement, oldest entry on ties.
// ----------------------------------------------------------------------------
//  channel   dir  handshake               payload
//  s_axis    in   s_axis_tvalid/tready    tdata {value, key}, tuser command
//  m_axis    out  m_axis_tvalid/tready    tdata read_value, tuser hit
//  cfg       in   cfg_valid/cfg_ready     cfg_data capacity_in_use
//
//  one request at a time: the result is offered after two passes (lookup, then
//  rank update) over the entry memory
//  the next request is accepted while the result waits in the output register
//  reset clears the valid bits at once; no clearing pass is needed
//  a stalled output holds the sequencer in its last step only
// ----------------------------------------------------------------------------
module lfu_cache_lru_tiebreak_core
    import lfu_lru_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [IN_W-1:0]    s_axis_tdata,   // key [31:0], value [63:32]
    input  logic [0:0]         s_axis_tuser,   // command [0]
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [DATA_W-1:0]  m_axis_tdata,   // read_value [31:0]
    output logic [0:0]         m_axis_tuser,   // hit [0]
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CFG_W-1:0]   cfg_data        // capacity_in_use [4:0]
);

    localparam int IDXW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    cmd_t            cmd;
    status_t         status;
    logic [IDXW-1:0] rd_addr;

    assign cfg_ready = 1'b1;

    // sequencer
    lfu_lru_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .status        (status),
        .cmd           (cmd),
        .rd_addr       (rd_addr)
    );

    // storage and compare logic
    lfu_lru_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .rd_addr    (rd_addr),
        .status     (status),
        .in_data    (s_axis_tdata),
        .in_command (s_axis_tuser[0]),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_hit    (m_axis_tuser[0]),
        .out_value  (m_axis_tdata)
    );

endmodule

/* rtl/core/lfu_lru_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_lru_ctrl
// Sequencer: lookup pass, decision, update pass, result hand-off.
// ----------------------------------------------------------------------------
module lfu_lru_ctrl
    import lfu_lru_pkg::*;
#(
    parameter int CAPACITY = 16,
    localparam int IDXW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  status_t             status,
    output cmd_t                cmd,
    output logic [IDXW-1:0]     rd_addr
);

    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(CAPACITY - 1);

    // state codes
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_SWAIT = 3'd2;
    localparam logic [2:0] S_PLAN  = 3'd3;
    localparam logic [2:0] S_UPD   = 3'd4;
    localparam logic [2:0] S_UWAIT = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]      state_reg;
    logic [2:0]      state_next;
    logic [IDXW-1:0] cnt_reg;
    logic [IDXW-1:0] cnt_next;

    assign rd_addr       = cnt_reg;
    assign s_axis_tready = (state_reg == S_IDLE);

    // next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = s_axis_tvalid;
                if (s_axis_tvalid)
                begin
                    state_next = S_SCAN;
                    cnt_next   = '0;
                end
            end
            S_SCAN:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_scan = 1'b1;
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = S_SWAIT;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_SWAIT:
            begin
                state_next = S_PLAN;
            end
            S_PLAN:
            begin
                cmd.plan   = 1'b1;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.rd_en = 1'b1;
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = S_UWAIT;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_UWAIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

/* rtl/core/lfu_lru_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_lru_dpath
// Entry memory, valid bits, lookup and victim search, rank update, result.
// ----------------------------------------------------------------------------
module lfu_lru_dpath
    import lfu_lru_pkg::*;
#(
    parameter int CAPACITY = 16,
    localparam int IDXW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    input  logic [IDXW-1:0]     rd_addr,
    output status_t             status,
    input  logic [IN_W-1:0]     in_data,
    input  logic                in_command,
    input  logic                cfg_valid,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic                out_ready,
    output logic                out_valid,
    output logic                out_hit,
    output logic [DATA_W-1:0]   out_value
);

    localparam int RANKW = IDXW;
    localparam int CNTW  = $clog2(CAPACITY + 1);
    localparam int CMPW  = (CNTW > CFG_W) ? CNTW : CFG_W;

    // entry memory
    logic [KEY_W-1:0]   mem_key   [CAPACITY];
    logic [DATA_W-1:0]  mem_data  [CAPACITY];
    logic [COUNT_W-1:0] mem_count [CAPACITY];
    logic [RANKW-1:0]   mem_rank  [CAPACITY];

    logic [CAPACITY-1:0] valid_reg;
    logic [CNTW-1:0]     occ_reg;
    logic [CFG_W-1:0]    cap_reg;

    // captured request
    logic               command_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [DATA_W-1:0]  value_reg;

    // read stage
    logic [KEY_W-1:0]   rd_key_reg;
    logic [DATA_W-1:0]  rd_data_reg;
    logic [COUNT_W-1:0] rd_count_reg;
    logic [RANKW-1:0]   rd_rank_reg;
    logic [IDXW-1:0]    rd_idx_reg;
    logic               rd_live_reg;
    logic               rd_scan_reg;

    // lookup pass results
    logic               match_found_reg;
    logic [IDXW-1:0]    match_idx_reg;
    logic [DATA_W-1:0]  match_data_reg;
    logic [RANKW-1:0]   match_rank_reg;
    logic               free_found_reg;
    logic [IDXW-1:0]    free_idx_reg;
    logic               vic_found_reg;
    logic [IDXW-1:0]    vic_idx_reg;
    logic [COUNT_W-1:0] vic_count_reg;
    logic [RANKW-1:0]   vic_rank_reg;

    // decision
    logic               touch_reg;
    logic               wdata_reg;
    logic               insert_reg;
    logic               evict_reg;
    logic [RANKW-1:0]   ref_rank_reg;
    logic [IDXW-1:0]    slot_reg;
    logic               res_hit_reg;
    logic [DATA_W-1:0]  res_value_reg;

    // output register
    logic               out_valid_reg;
    logic               out_hit_reg;
    logic [DATA_W-1:0]  out_value_reg;

    logic               rd_valid;
    logic               wr_en;
    logic [KEY_W-1:0]   key_next;
    logic [DATA_W-1:0]  data_next;
    logic [COUNT_W-1:0] count_next;
    logic [RANKW-1:0]   rank_next;

    logic [CMPW-1:0]    cap_ext;
    logic [CMPW-1:0]    cap_eff;
    logic [CMPW-1:0]    occ_ext;
    logic               cap_zero;
    logic               is_put;
    logic               plan_touch;
    logic               plan_insert;
    logic               plan_evict;
    logic               vic_better;

    assign rd_valid = valid_reg[rd_idx_reg];
    assign wr_en    = rd_live_reg && !rd_scan_reg;

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_hit   = out_hit_reg;
    assign out_value = out_value_reg;

    // capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_valid)
        begin
            cap_reg <= cfg_data;
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            command_reg <= in_command;
            key_reg     <= in_data[KEY_W-1:0];
            value_reg   <= in_data[IN_W-1:KEY_W];
        end
    end

    // memory read and write-back
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_key_reg   <= mem_key[rd_addr];
            rd_data_reg  <= mem_data[rd_addr];
            rd_count_reg <= mem_count[rd_addr];
            rd_rank_reg  <= mem_rank[rd_addr];
            rd_idx_reg   <= rd_addr;
        end
        if (wr_en)
        begin
            mem_key[rd_idx_reg]   <= key_next;
            mem_data[rd_idx_reg]  <= data_next;
            mem_count[rd_idx_reg] <= count_next;
            mem_rank[rd_idx_reg]  <= rank_next;
        end
    end

    // read stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_live_reg <= 1'b0;
            rd_scan_reg <= 1'b0;
        end
        else
        begin
            rd_live_reg <= cmd.rd_en;
            rd_scan_reg <= cmd.rd_scan;
        end
    end

    // victim order: lower count, then older rank
    assign vic_better = !vic_found_reg || (rd_count_reg < vic_count_reg) ||
                        ((rd_count_reg == vic_count_reg) && (rd_rank_reg > vic_rank_reg));

    // lookup pass: key match, first free slot, eviction victim
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            vic_found_reg   <= 1'b0;
        end
        else if (cmd.load)
        begin
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            vic_found_reg   <= 1'b0;
        end
        else if (rd_live_reg && rd_scan_reg)
        begin
            if (rd_valid && (rd_key_reg == key_reg) && !match_found_reg)
            begin
                match_found_reg <= 1'b1;
            end
            if (!rd_valid && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
            end
            if (rd_valid && vic_better)
            begin
                vic_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_live_reg && rd_scan_reg)
        begin
            if (rd_valid && (rd_key_reg == key_reg) && !match_found_reg)
            begin
                match_idx_reg  <= rd_idx_reg;
                match_data_reg <= rd_data_reg;
                match_rank_reg <= rd_rank_reg;
            end
            if (!rd_valid && !free_found_reg)
            begin
                free_idx_reg <= rd_idx_reg;
            end
            if (rd_valid && vic_better)
            begin
                vic_idx_reg   <= rd_idx_reg;
                vic_count_reg <= rd_count_reg;
                vic_rank_reg  <= rd_rank_reg;
            end
        end
    end

    // decision after the lookup pass
    assign cap_ext     = CMPW'(cap_reg);
    assign cap_eff     = (cap_ext > CMPW'(CAPACITY)) ? CMPW'(CAPACITY) : cap_ext;
    assign occ_ext     = CMPW'(occ_reg);
    assign cap_zero    = (cap_eff == '0);
    assign is_put      = (command_reg == CMD_PUT);
    assign plan_touch  = match_found_reg && (!is_put || !cap_zero);
    assign plan_insert = is_put && !match_found_reg && !cap_zero;
    assign plan_evict  = plan_insert && (occ_ext >= cap_eff) && vic_found_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            touch_reg  <= 1'b0;
            wdata_reg  <= 1'b0;
            insert_reg <= 1'b0;
            evict_reg  <= 1'b0;
        end
        else if (cmd.plan)
        begin
            touch_reg  <= plan_touch;
            wdata_reg  <= plan_touch && is_put;
            insert_reg <= plan_insert;
            evict_reg  <= plan_evict;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.plan)
        begin
            ref_rank_reg <= plan_touch ? match_rank_reg : vic_rank_reg;
            if (plan_evict && (!free_found_reg || (vic_idx_reg < free_idx_reg)))
            begin
                slot_reg <= vic_idx_reg;
            end
            else
            begin
                slot_reg <= free_idx_reg;
            end
            res_hit_reg <= match_found_reg;
            if (is_put)
            begin
                res_value_reg <= PUT_VALUE;
            end
            else if (match_found_reg)
            begin
                res_value_reg <= match_data_reg;
            end
            else
            begin
                res_value_reg <= MISS_VALUE;
            end
        end
    end

    // update pass: new contents of the entry being written back
    always_comb
    begin
        key_next   = rd_key_reg;
        data_next  = rd_data_reg;
        count_next = rd_count_reg;
        rank_next  = rd_rank_reg;
        if (touch_reg)
        begin
            if (rd_idx_reg == match_idx_reg)
            begin
                rank_next = '0;
                if (rd_count_reg != COUNT_MAX)
                begin
                    count_next = rd_count_reg + 1'b1;
                end
                if (wdata_reg)
                begin
                    data_next = value_reg;
                end
            end
            else if (rd_valid && (rd_rank_reg < ref_rank_reg))
            begin
                rank_next = rd_rank_reg + 1'b1;
            end
        end
        else if (insert_reg)
        begin
            if (rd_idx_reg == slot_reg)
            begin
                key_next   = key_reg;
                data_next  = value_reg;
                count_next = COUNT_INIT;
                rank_next  = '0;
            end
            else if (rd_valid && !(evict_reg && (rd_idx_reg == vic_idx_reg)))
            begin
                // removal shifts older ranks down, insertion shifts all up
                if (!(evict_reg && (rd_rank_reg > ref_rank_reg)))
                begin
                    rank_next = rd_rank_reg + 1'b1;
                end
            end
        end
    end

    // valid bits and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            occ_reg   <= '0;
        end
        else if (cmd.commit && insert_reg)
        begin
            if (evict_reg)
            begin
                valid_reg[vic_idx_reg] <= 1'b0;
            end
            else
            begin
                occ_reg <= occ_reg + 1'b1;
            end
            valid_reg[slot_reg] <= 1'b1;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_hit_reg   <= res_hit_reg;
            out_value_reg <= res_value_reg;
        end
    end

endmodule

/* rtl/core/lfu_lru_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_lru_checker
// Port-level checks for the cache core, attached by bind.
// ----------------------------------------------------------------------------
module lfu_lru_checker
    import lfu_lru_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    input  logic               s_axis_tready,
    input  logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    input  logic [DATA_W-1:0]  m_axis_tdata,
    input  logic [0:0]         m_axis_tuser
);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result payload changed while stalled");

    // the core is busy right after taking a request
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while busy");

    // a miss returns either the miss marker or the put result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |->
            (m_axis_tdata == MISS_VALUE) || (m_axis_tdata == PUT_VALUE))
        else $error("miss with unexpected read value");

endmodule

bind lfu_cache_lru_tiebreak_core lfu_lru_checker u_checker (.*);

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the lfu cache core with lru tie-break.
// Drives get and put requests on the stream input and writes the capacity
// register between phases. An in-bench cache predictor supplies the expected
// hit flag and read value for every request. Both stream sides idle at
// random, and each returned transfer is checked in order.
// ----------------------------------------------------------------------------
module tb;
    import lfu_lru_pkg::*;

    localparam int SLOTS          = 16;
    localparam int RESULT_LATENCY = 2 * SLOTS + 5;
    localparam int QUIET_LIMIT    = 2000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] read_value;
    } lookup_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata = '0;
    logic [0:0]        s_axis_tuser = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [DATA_W-1:0] m_axis_tdata;
    logic [0:0]        m_axis_tuser;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_data = '0;

    // predicted cache contents
    bit                 model_valid [SLOTS];
    logic [KEY_W-1:0]   model_key   [SLOTS];
    logic [DATA_W-1:0]  model_data  [SLOTS];
    logic [COUNT_W-1:0] model_uses  [SLOTS];
    int                 model_age   [SLOTS];
    int                 model_fill = 0;
    logic [CFG_W-1:0]   model_cap_reg = CAP_RESET;

    lookup_result_t pending_results [$];

    bit          sender_idle_on = 1'b0;
    bit          receiver_idle_on = 1'b0;
    bit          valid_held = 1'b0;
    logic [31:0] key_base;
    int          ready_hold = 0;
    int          quiet_cycles = 0;
    int          fail_count = 0;
    int          items_sent = 0;
    int          lookups_hit = 0;
    int          results_checked = 0;
    int          cfg_writes = 0;

    lfu_cache_lru_tiebreak_core #(
        .CAPACITY (SLOTS)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // cache predictor
    // ------------------------------------------------------------------------

    // make an entry the most recent one and raise its use count
    function automatic void promote_entry(input int s);
        int i;
        for (i = 0; i < SLOTS; i++)
            if (i != s && model_valid[i] && model_age[i] < model_age[s])
                model_age[i]++;
        model_age[s] = 0;
        if (model_uses[s] != COUNT_MAX)
            model_uses[s] = model_uses[s] + 1;
    endfunction

    function automatic lookup_result_t cache_lookup(input logic cmd,
                                                    input logic [KEY_W-1:0] k,
                                                    input logic [DATA_W-1:0] d);
        lookup_result_t res;
        int i;
        int slot;
        int victim;
        int free_slot;
        int limit;
        slot = -1;
        victim = -1;
        free_slot = -1;
        limit = (model_cap_reg > SLOTS) ? SLOTS : int'(model_cap_reg);
        for (i = 0; i < SLOTS; i++)
            if (slot < 0 && model_valid[i] && model_key[i] == k)
                slot = i;
        res.hit = (slot >= 0);
        res.read_value = PUT_VALUE;
        if (cmd == CMD_GET)
        begin
            if (slot >= 0)
            begin
                res.read_value = model_data[slot];
                promote_entry(slot);
            end
            else
                res.read_value = MISS_VALUE;
        end
        else if (limit != 0)
        begin
            if (slot >= 0)
            begin
                model_data[slot] = d;
                promote_entry(slot);
            end
            else
            begin
                // full: lowest count goes, oldest among equal counts
                if (model_fill >= limit)
                begin
                    for (i = 0; i < SLOTS; i++)
                        if (model_valid[i] && (victim < 0
                            || model_uses[i] < model_uses[victim]
                            || (model_uses[i] == model_uses[victim]
                                && model_age[i] > model_age[victim])))
                            victim = i;
                    if (victim >= 0)
                    begin
                        model_valid[victim] = 1'b0;
                        for (i = 0; i < SLOTS; i++)
                            if (model_valid[i] && model_age[i] > model_age[victim])
                                model_age[i]--;
                        if (model_fill > 0)
                            model_fill--;
                    end
                end
                // new entry into the lowest free slot
                for (i = 0; i < SLOTS; i++)
                    if (free_slot < 0 && !model_valid[i])
                        free_slot = i;
                if (free_slot >= 0)
                begin
                    for (i = 0; i < SLOTS; i++)
                        if (model_valid[i])
                            model_age[i]++;
                    model_valid[free_slot] = 1'b1;
                    model_key[free_slot] = k;
                    model_data[free_slot] = d;
                    model_uses[free_slot] = COUNT_INIT;
                    model_age[free_slot] = 0;
                    model_fill++;
                end
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // shared helpers
    // ------------------------------------------------------------------------

    function automatic void note_failure(input string msg);
        if (fail_count < REPORT_LIMIT)
            $display("%s", msg);
        fail_count++;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // one request transfer, expectation queued on acceptance
    task automatic send_request(input logic cmd, input logic [KEY_W-1:0] k,
                                input logic [DATA_W-1:0] d);
        int gap;
        lookup_result_t want;
        gap = sender_idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            if (valid_held)
                s_axis_tvalid <= 1'b0;
            valid_held = 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {d, k};
        s_axis_tuser <= cmd;
        do
            @(posedge clk);
        while (!s_axis_tready);
        valid_held = 1'b1;
        want = cache_lookup(cmd, k, d);
        if (want.hit)
            lookups_hit++;
        pending_results.push_back(want);
        items_sent++;
    endtask

    // stop sending and hold off until every result is back
    task automatic wait_drained();
        if (valid_held)
            s_axis_tvalid <= 1'b0;
        valid_held = 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    task automatic write_capacity(input logic [CFG_W-1:0] cap);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= cap;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        model_cap_reg = cap;
        cfg_writes++;
    endtask

    // ------------------------------------------------------------------------
    // result side: ready pattern, checking, watchdog
    // ------------------------------------------------------------------------

    always @(posedge clk)
    begin : ready_gen
        int roll;
        if (!receiver_idle_on)
        begin
            m_axis_tready <= 1'b1;
            ready_hold = 0;
        end
        else if (ready_hold == 0)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 65)
            begin
                m_axis_tready <= 1'b1;
                ready_hold = $urandom_range(0, 7);
            end
            else if (roll < 95)
            begin
                m_axis_tready <= 1'b0;
                ready_hold = $urandom_range(0, 2);
            end
            else
            begin
                m_axis_tready <= 1'b0;
                ready_hold = $urandom_range(9, 39);
            end
        end
        else
            ready_hold--;
    end

    always @(posedge clk)
    begin : result_check
        lookup_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
                note_failure($sformatf("unexpected result: hit %0b value %h",
                                       m_axis_tuser[0], m_axis_tdata));
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tuser[0] !== want.hit)
                    note_failure($sformatf("result %0d: hit expected %0b got %0b",
                                           results_checked, want.hit, m_axis_tuser[0]));
                if (m_axis_tdata !== want.read_value)
                    note_failure($sformatf("result %0d: read_value expected %h got %h",
                                           results_checked, want.read_value,
                                           m_axis_tdata));
            end
            results_checked++;
        end
    end

    // end the run if no transfer moves for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     QUIET_LIMIT, pending_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // gets and puts at reset capacity, extreme keys and values
    task automatic test_basic_access();
        sender_idle_on = 1'b1;
        receiver_idle_on = 1'b1;
        send_request(CMD_GET, 32'h0000_0000, 32'h0000_0000);
        send_request(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        send_request(CMD_PUT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_request(CMD_GET, 32'h7FFF_FFFF, 32'h1234_5678);
        send_request(CMD_PUT, 32'h0000_0000, 32'h0000_0000);
        send_request(CMD_GET, 32'h8000_0000, 32'hFFFF_FFFF);
    endtask

    // capacity below occupancy: every new key evicts exactly one entry
    task automatic test_shrink_below_occupancy();
        write_capacity(5'd1);
        send_request(CMD_PUT, 32'h0000_0005, 32'hA5A5_A5A5);
        send_request(CMD_PUT, 32'h0000_0006, 32'h5A5A_5A5A);
        send_request(CMD_GET, 32'h0000_0006, 32'h0000_0000);
    endtask

    // capacity zero: puts change nothing but still report presence
    task automatic test_capacity_zero();
        write_capacity(5'd0);
        send_request(CMD_PUT, 32'h0000_0007, 32'h1111_1111);
        send_request(CMD_PUT, 32'h0000_0006, 32'h2222_2222);
        send_request(CMD_GET, 32'h0000_0006, 32'h0000_0000);
    endtask

    // register above the store size is clamped
    task automatic test_capacity_clamp();
        write_capacity(5'd31);
        send_request(CMD_PUT, 32'h0000_0009, 32'hDEAD_BEEF);
        send_request(CMD_PUT, 32'hFFFF_FFFF, 32'h0BAD_F00D);
        send_request(CMD_GET, 32'h0000_0009, 32'h0000_0000);
    endtask

    // random gets and puts over a key pool sized to force hits and evictions
    task automatic test_random_mix(input logic [CFG_W-1:0] cap, input int key_span,
                                   input int count, input bit tx_idle,
                                   input bit rx_idle);
        int n;
        int roll;
        logic cmd;
        logic [KEY_W-1:0] k;
        write_capacity(cap);
        sender_idle_on = tx_idle;
        receiver_idle_on = rx_idle;
        for (n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 99) < 3)
                wait_drained();
            cmd = ($urandom_range(0, 1) == 1) ? CMD_PUT : CMD_GET;
            roll = $urandom_range(0, 99);
            if (roll < 85)
                k = key_base + $urandom_range(0, key_span - 1);
            else if (roll < 95)
                k = $urandom;
            else
            begin
                case ($urandom_range(0, 3))
                    0: k = 32'h8000_0000;
                    1: k = 32'h7FFF_FFFF;
                    2: k = 32'hFFFF_FFFF;
                    default: k = 32'h0000_0000;
                endcase
            end
            send_request(cmd, k, $urandom);
        end
    endtask

    initial
    begin
        key_base = $urandom;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_basic_access();
        test_shrink_below_occupancy();
        test_capacity_zero();
        test_capacity_clamp();

        test_random_mix(5'd16, 24, 260, 1'b1, 1'b1);
        test_random_mix(5'd1,  3,  160, 1'b0, 1'b0);
        test_random_mix(5'd3,  6,  200, 1'b1, 1'b1);
        test_random_mix(5'd8,  12, 200, 1'b1, 1'b0);
        test_random_mix(5'd0,  10, 120, 1'b1, 1'b1);
        test_random_mix(5'd31, 24, 260, 1'b1, 1'b1);
        test_random_mix(5'd5,  8,  200, 1'b0, 1'b1);

        // drain, then give a stray result time to show up
        wait_drained();
        repeat (RESULT_LATENCY + 20) @(posedge clk);
        if (pending_results.size() != 0)
            note_failure($sformatf("%0d results never arrived", pending_results.size()));

        $display("covered %0d requests (%0d hits) under %0d capacity writes",
                 items_sent, lookups_hit, cfg_writes);
        $display("checked %0d results, %0d failures", results_checked, fail_count);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* files.f */
rtl/core/lfu_lru_pkg.sv
rtl/core/lfu_lru_ctrl.sv
rtl/core/lfu_lru_dpath.sv
rtl/core/lfu_cache_lru_tiebreak_core.sv
rtl/core/lfu_lru_checker.sv
test/tb.sv
